### design/assert_macros.svh
// assertion macros used by the ray unit design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, off while reset is low
`define HGRH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same check written as antecedent and consequent in the same cycle
`define HGRH_ASSERT_IMPL(lbl, ante, cons, msg) \
	`HGRH_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### design/hgrh_pkg.sv
// shared types and constants of the height-field ray unit
`default_nettype none

package hgrh_pkg;

	localparam int COORD_W = 24;
	localparam int CFG_W   = 9;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		OUT_NONE  = 3'd0,
		OUT_START = 3'd1,
		OUT_TOP   = 3'd2,
		OUT_MX    = 3'd3,
		OUT_PX    = 3'd4,
		OUT_MY    = 3'd5,
		OUT_PY    = 3'd6
	} outcome_t;

	typedef struct packed {
		logic busy;
		logic done;
	} md_stat_t;

endpackage

`default_nettype wire

### design/hgrh_muldiv.sv
// shared multiply then restoring divide unit: trunc(d * num / den)
`default_nettype none

module hgrh_muldiv import hgrh_pkg::*; #(
	parameter int DW = 26,
	parameter int NW = 25,
	parameter int QW = 27
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  go,
	input  wire signed [DW-1:0]  d,
	input  wire signed [NW-1:0]  num,
	input  wire signed [DW-1:0]  den,
	output md_stat_t             stat,
	output logic signed [QW-1:0] quot
);

	localparam int PRW  = DW + NW;
	localparam int CNTW = $clog2(PRW);
	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(PRW - 1);

	typedef enum logic [1:0] {P_IDLE, P_MUL, P_DIV, P_FIN} phase_t;

	phase_t                 phase_q;
	logic                   done_q;
	logic [CNTW-1:0]        cnt_q;
	logic signed [DW-1:0]   a_q;
	logic signed [NW-1:0]   b_q;
	logic [DW-1:0]          den_q;
	logic                   neg_q;
	logic [PRW-1:0]         dvd_q;
	logic [DW-1:0]          rem_q;
	logic signed [QW-1:0]   quot_q;

	logic signed [PRW-1:0]  prod;
	logic [PRW-1:0]         prod_mag;
	logic [DW:0]            trial;
	logic [DW:0]            diff;
	logic                   ge;
	logic signed [QW-1:0]   qmag;

	assign prod     = PRW'(a_q) * PRW'(b_q);
	assign prod_mag = prod[PRW-1] ? PRW'(-prod) : PRW'(prod);
	assign trial    = {rem_q, dvd_q[PRW-1]};
	assign diff     = trial - {1'b0, den_q};
	assign ge       = trial >= {1'b0, den_q};
	assign qmag     = $signed(dvd_q[QW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (go) begin
						phase_q <= P_MUL;
					end
				end
				P_MUL: begin
					cnt_q   <= '0;
					phase_q <= P_DIV;
				end
				P_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						phase_q <= P_FIN;
					end
				end
				P_FIN: begin
					done_q  <= 1'b1;
					phase_q <= P_IDLE;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (phase_q)
			P_IDLE: begin
				if (go) begin
					a_q   <= d;
					b_q   <= num;
					den_q <= den;
				end
			end
			P_MUL: begin
				neg_q <= prod[PRW-1];
				dvd_q <= prod_mag;
				rem_q <= '0;
			end
			P_DIV: begin
				// quotient bits shift in where dividend bits leave
				rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
				dvd_q <= {dvd_q[PRW-2:0], ge};
			end
			P_FIN: begin
				quot_q <= neg_q ? -qmag : qmag;
			end
			default: begin
			end
		endcase
	end

	assign stat.busy = (phase_q != P_IDLE);
	assign stat.done = done_q;
	assign quot      = quot_q;

endmodule

`default_nettype wire

### design/heightfield_grid_ray_hit_unit.sv
// Height-field grid ray unit: a cell store loaded by write words and a ray walk over it.
// On a cell write busy stays low and done pulses in the next cycle. A query first reads
// the start cell (init, address, read, check), then walks the grid along the major axis.
// Each step tests its three cells with up to 5 face tests each, then makes one pass
// through the shared multiply-divide unit for the side coordinate. Every crossing that
// a face test finds costs three passes and a hit check. A pass multiplies, then runs a
// restoring divide over the DW + NW bits of the product. The result is shown for one
// cycle with done high and cannot be held off, so take it then.
`default_nettype none
`include "assert_macros.svh"

module heightfield_grid_ray_hit_unit import hgrh_pkg::*; #(
	parameter int MAX_SIDE  = 256,
	parameter int FRAC_BITS = 8
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  wire                       func,
	input  wire [15:0]                cell_index,
	input  wire                       cell_passable,
	input  wire [6:0]                 cell_height,
	input  wire signed [COORD_W-1:0]  start_x,
	input  wire signed [COORD_W-1:0]  start_y,
	input  wire signed [COORD_W-1:0]  start_z,
	input  wire signed [COORD_W-1:0]  end_x,
	input  wire signed [COORD_W-1:0]  end_y,
	input  wire signed [COORD_W-1:0]  end_z,
	input  wire                       wr_en,
	input  wire [0:0]                 wr_index,
	input  wire [CFG_W-1:0]           wr_data,
	output logic                      done,
	output logic                      hit,
	output logic [2:0]                outcome,
	output logic signed [COORD_W-1:0] hit_x,
	output logic signed [COORD_W-1:0] hit_y,
	output logic signed [COORD_W-1:0] hit_z
);

	localparam int SCALE = 1 << FRAC_BITS;
	localparam int GW    = $clog2(MAX_SIDE + 1);
	localparam int MAG   = ($clog2(MAX_SIDE) + FRAC_BITS > COORD_W - 1) ?
	                       $clog2(MAX_SIDE) + FRAC_BITS : COORD_W - 1;
	localparam int NW    = MAG + 2;
	localparam int DW    = COORD_W + 2;
	localparam int PW    = NW + 2;
	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(DEPTH);

	localparam logic signed [PW-1:0] P_ONE = PW'(1);
	localparam logic signed [PW-1:0] P_SM1 = PW'(SCALE - 1);
	localparam logic [CFG_W-1:0]     CFG_RESET = CFG_W'(64);

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_SADDR, S_SRD, S_SCHK, S_LOOP, S_NADDR, S_NRD, S_NDATA,
		S_SUB, S_LERP, S_LWAIT, S_HCHK, S_MISS, S_NBDONE, S_STEP, S_SWAIT
	} state_t;

	typedef enum logic [1:0] {M_XP, M_XN, M_YP, M_YN} mode_t;
	typedef enum logic [1:0] {NB_MID, NB_LO, NB_HI} nb_t;
	typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_t;
	typedef enum logic [2:0] {SUB_TOP, SUB_MX, SUB_PX, SUB_MY, SUB_PY} sub_t;

	function automatic logic signed [PW-1:0] sx(input logic signed [COORD_W-1:0] v);
		return PW'(v);
	endfunction

	// divide by the cell size, rounding toward zero
	function automatic logic signed [PW-1:0] tdiv(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] b;
		b = v[PW-1] ? v + P_SM1 : v;
		return b >>> FRAC_BITS;
	endfunction

	function automatic logic [GW-1:0] clamp_side(input logic [CFG_W-1:0] v);
		logic [GW-1:0] r;
		if (v == '0) begin
			r = GW'(1);
		end else if (32'(v) > MAX_SIDE) begin
			r = GW'(MAX_SIDE);
		end else begin
			r = GW'(v);
		end
		return r;
	endfunction

	function automatic logic in_grid(input logic signed [PW-1:0] cx,
	                                 input logic signed [PW-1:0] cy,
	                                 input logic [GW-1:0] w, input logic [GW-1:0] h);
		return !cx[PW-1] && !cy[PW-1] && (cx < $signed(PW'(w))) && (cy < $signed(PW'(h)));
	endfunction

	function automatic outcome_t sub_code(input sub_t s);
		outcome_t r;
		unique case (s)
			SUB_TOP: r = OUT_TOP;
			SUB_MX:  r = OUT_MX;
			SUB_PX:  r = OUT_PX;
			SUB_MY:  r = OUT_MY;
			SUB_PY:  r = OUT_PY;
			default: r = OUT_NONE;
		endcase
		return r;
	endfunction

	function automatic sub_t sub_next(input sub_t s);
		sub_t r;
		unique case (s)
			SUB_TOP: r = SUB_MX;
			SUB_MX:  r = SUB_PX;
			SUB_PX:  r = SUB_MY;
			default: r = SUB_PY;
		endcase
		return r;
	endfunction

	// control and configuration
	state_t                  state_q;
	logic                    md_go_q;
	logic [CFG_W-1:0]        width_q;
	logic [CFG_W-1:0]        height_q;

	// datapath
	logic [GW-1:0]           gw_q, gh_q;
	logic signed [PW-1:0]    a1x_q, a1y_q, a1z_q, a2x_q, a2y_q, a2z_q;
	logic signed [DW-1:0]    dx_q, dy_q, dz_q, adx_q, ady_q;
	logic signed [PW-1:0]    i_q, j_q, ei_q, ej_q;
	mode_t                   mode_q;
	nb_t                     nb_q;
	sub_t                    sub_q;
	axis_t                   axis_q;
	logic                    pass_q;
	logic signed [PW-1:0]    h_q, x1_q, x2_q, y1_q, y2_q;
	logic signed [NW-1:0]    num_q;
	logic signed [DW-1:0]    den_q;
	logic signed [PW-1:0]    qx_q, qy_q, qz_q;
	logic signed [DW-1:0]    md_d_q;
	logic signed [NW-1:0]    md_num_q;
	logic signed [DW-1:0]    md_den_q;
	logic [AW-1:0]           addr_q;

	// cell store: bit 7 passable, bits 6..0 height
	logic [7:0]              mem [DEPTH];
	logic [7:0]              rdata_q;

	md_stat_t                md_stat;
	logic signed [PW-1:0]    md_quot;

	logic                    acc, mem_we;
	logic signed [PW-1:0]    dxw, dyw, adxw, adyw;
	logic signed [PW-1:0]    nbx, nby, selx, sely;
	logic [2*GW-1:0]         addr_sum;
	logic                    in_ij, in_c, past_end, xmode, last_sub, start_solid;
	logic signed [PW-1:0]    hdata;
	logic                    sub_cond;
	logic signed [PW-1:0]    sub_num, sub_den;
	logic                    inx, iny, below, hit_now;
	logic signed [PW-1:0]    stp_major, stp_num, lerp_sum;
	logic signed [DW-1:0]    axis_d;

	assign busy   = (state_q != S_IDLE);
	assign acc    = start && !busy;
	assign mem_we = acc && (func == FUNC_WRITE) && (32'(cell_index) < DEPTH);

	assign dxw  = a2x_q - a1x_q;
	assign dyw  = a2y_q - a1y_q;
	assign adxw = dxw[PW-1] ? -dxw : dxw;
	assign adyw = dyw[PW-1] ? -dyw : dyw;

	assign xmode = (mode_q == M_XP) || (mode_q == M_XN);

	always_comb begin
		nbx = i_q;
		nby = j_q;
		unique case (nb_q)
			NB_LO: begin
				if (xmode) nby = j_q - P_ONE;
				else       nbx = i_q - P_ONE;
			end
			NB_HI: begin
				if (xmode) nby = j_q + P_ONE;
				else       nbx = i_q + P_ONE;
			end
			default: begin
			end
		endcase
	end

	assign selx     = (state_q == S_SADDR) ? i_q : nbx;
	assign sely     = (state_q == S_SADDR) ? j_q : nby;
	assign addr_sum = sely[GW-1:0] * gw_q + (2*GW)'(selx[GW-1:0]);

	assign in_ij = in_grid(i_q, j_q, gw_q, gh_q);
	assign in_c  = in_grid(nbx, nby, gw_q, gh_q);
	assign hdata = $signed(PW'(rdata_q[6:0])) <<< FRAC_BITS;
	assign start_solid = !rdata_q[7] && (a1z_q < hdata);
	assign last_sub    = pass_q || (sub_q == SUB_PY);

	always_comb begin
		unique case (mode_q)
			M_XP: past_end = i_q > ei_q;
			M_XN: past_end = i_q < ei_q;
			M_YP: past_end = j_q > ej_q;
			default: past_end = j_q < ej_q;
		endcase
	end

	// crossing condition and lerp fraction of each face test
	always_comb begin
		unique case (sub_q)
			SUB_TOP: begin
				sub_cond = (a1z_q > h_q) && (a2z_q <= h_q);
				sub_num  = a1z_q - h_q;
				sub_den  = a1z_q - a2z_q;
			end
			SUB_MX: begin
				sub_cond = (a1x_q <= x1_q) && (a2x_q > x1_q);
				sub_num  = x1_q - a1x_q;
				sub_den  = a2x_q - a1x_q;
			end
			SUB_PX: begin
				sub_cond = (a1x_q >= x2_q) && (a2x_q < x2_q);
				sub_num  = a1x_q - x2_q;
				sub_den  = a1x_q - a2x_q;
			end
			SUB_MY: begin
				sub_cond = (a1y_q <= y1_q) && (a2y_q > y1_q);
				sub_num  = y1_q - a1y_q;
				sub_den  = a2y_q - a1y_q;
			end
			default: begin
				sub_cond = (a1y_q >= y2_q) && (a2y_q < y2_q);
				sub_num  = a1y_q - y2_q;
				sub_den  = a1y_q - a2y_q;
			end
		endcase
	end

	assign inx   = (qx_q >= x1_q) && (qx_q <= x2_q);
	assign iny   = (qy_q >= y1_q) && (qy_q <= y2_q);
	assign below = qz_q < h_q;

	always_comb begin
		unique case (sub_q)
			SUB_TOP:         hit_now = inx && iny;
			SUB_MX, SUB_PX:  hit_now = iny && below;
			default:         hit_now = inx && below;
		endcase
	end

	always_comb begin
		unique case (mode_q)
			M_XP: begin
				stp_major = i_q + P_ONE;
				stp_num   = ((i_q + P_ONE) <<< FRAC_BITS) - a1x_q;
			end
			M_XN: begin
				stp_major = i_q - P_ONE;
				stp_num   = a1x_q - (i_q <<< FRAC_BITS);
			end
			M_YP: begin
				stp_major = j_q + P_ONE;
				stp_num   = ((j_q + P_ONE) <<< FRAC_BITS) - a1y_q;
			end
			default: begin
				stp_major = j_q - P_ONE;
				stp_num   = a1y_q - (j_q <<< FRAC_BITS);
			end
		endcase
	end

	always_comb begin
		unique case (axis_q)
			AX_X:    axis_d = dx_q;
			AX_Y:    axis_d = dy_q;
			default: axis_d = dz_q;
		endcase
	end

	always_comb begin
		unique case (axis_q)
			AX_X:    lerp_sum = a1x_q + md_quot;
			AX_Y:    lerp_sum = a1y_q + md_quot;
			default: lerp_sum = a1z_q + md_quot;
		endcase
	end

	hgrh_muldiv #(
		.DW(DW),
		.NW(NW),
		.QW(PW)
	) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (md_go_q),
		.d     (md_d_q),
		.num   (md_num_q),
		.den   (md_den_q),
		.stat  (md_stat),
		.quot  (md_quot)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(cell_index)] <= {cell_passable, cell_height};
		end
		rdata_q <= mem[addr_q];
	end

	// state, configuration and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			md_go_q  <= 1'b0;
			width_q  <= CFG_RESET;
			height_q <= CFG_RESET;
			done     <= 1'b0;
			hit      <= 1'b0;
			outcome  <= OUT_NONE;
			hit_x    <= '0;
			hit_y    <= '0;
			hit_z    <= '0;
		end else begin
			done    <= 1'b0;
			md_go_q <= 1'b0;
			if (wr_en) begin
				if (wr_index == REG_WIDTH) width_q  <= wr_data;
				else                       height_q <= wr_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (func == FUNC_WRITE) begin
							done    <= 1'b1;
							hit     <= 1'b0;
							outcome <= OUT_NONE;
							hit_x   <= '0;
							hit_y   <= '0;
							hit_z   <= '0;
						end else begin
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: state_q <= S_SADDR;
				S_SADDR: begin
					if (in_ij) begin
						state_q <= S_SRD;
					end else begin
						done    <= 1'b1;
						hit     <= 1'b0;
						outcome <= OUT_NONE;
						hit_x   <= a2x_q[COORD_W-1:0];
						hit_y   <= a2y_q[COORD_W-1:0];
						hit_z   <= a2z_q[COORD_W-1:0];
						state_q <= S_IDLE;
					end
				end
				S_SRD: state_q <= S_SCHK;
				S_SCHK: begin
					if (start_solid) begin
						done    <= 1'b1;
						hit     <= 1'b1;
						outcome <= OUT_START;
						hit_x   <= a1x_q[COORD_W-1:0];
						hit_y   <= a1y_q[COORD_W-1:0];
						hit_z   <= a1z_q[COORD_W-1:0];
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LOOP;
					end
				end
				S_LOOP: begin
					if (!in_ij || past_end) begin
						done    <= 1'b1;
						hit     <= 1'b0;
						outcome <= OUT_NONE;
						hit_x   <= a2x_q[COORD_W-1:0];
						hit_y   <= a2y_q[COORD_W-1:0];
						hit_z   <= a2z_q[COORD_W-1:0];
						state_q <= S_IDLE;
					end else begin
						state_q <= S_NADDR;
					end
				end
				S_NADDR: state_q <= in_c ? S_NRD : S_NBDONE;
				S_NRD:   state_q <= S_NDATA;
				S_NDATA: state_q <= S_SUB;
				S_SUB:   state_q <= sub_cond ? S_LERP : S_MISS;
				S_LERP: begin
					md_go_q <= 1'b1;
					state_q <= S_LWAIT;
				end
				S_LWAIT: begin
					if (md_stat.done) begin
						state_q <= (axis_q == AX_Z) ? S_HCHK : S_LERP;
					end
				end
				S_HCHK: begin
					if (hit_now) begin
						done    <= 1'b1;
						hit     <= 1'b1;
						outcome <= sub_code(sub_q);
						hit_x   <= qx_q[COORD_W-1:0];
						hit_y   <= qy_q[COORD_W-1:0];
						hit_z   <= qz_q[COORD_W-1:0];
						state_q <= S_IDLE;
					end else begin
						state_q <= S_MISS;
					end
				end
				S_MISS: state_q <= last_sub ? S_NBDONE : S_SUB;
				S_NBDONE: begin
					if (nb_q != NB_HI) begin
						state_q <= S_NADDR;
					end else if (!xmode && (ady_q == '0)) begin
						// no span along the major axis: a single step only
						done    <= 1'b1;
						hit     <= 1'b0;
						outcome <= OUT_NONE;
						hit_x   <= a2x_q[COORD_W-1:0];
						hit_y   <= a2y_q[COORD_W-1:0];
						hit_z   <= a2z_q[COORD_W-1:0];
						state_q <= S_IDLE;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					md_go_q <= 1'b1;
					state_q <= S_SWAIT;
				end
				S_SWAIT: begin
					if (md_stat.done) begin
						state_q <= S_LOOP;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					gw_q  <= clamp_side(width_q);
					gh_q  <= clamp_side(height_q);
					a1x_q <= sx(start_x);
					a1y_q <= sx(start_y);
					a1z_q <= sx(start_z);
					a2x_q <= sx(end_x);
					a2y_q <= sx(end_y);
					a2z_q <= sx(end_z);
				end
			end
			S_INIT: begin
				i_q   <= tdiv(a1x_q);
				j_q   <= tdiv(a1y_q);
				ei_q  <= tdiv(a2x_q);
				ej_q  <= tdiv(a2y_q);
				dx_q  <= DW'(dxw);
				dy_q  <= DW'(dyw);
				dz_q  <= DW'(a2z_q - a1z_q);
				adx_q <= DW'(adxw);
				ady_q <= DW'(adyw);
				if (adxw > adyw) mode_q <= (a2x_q > a1x_q) ? M_XP : M_XN;
				else             mode_q <= (a2y_q > a1y_q) ? M_YP : M_YN;
			end
			S_SADDR, S_NADDR: begin
				addr_q <= AW'(addr_sum);
			end
			S_LOOP: begin
				nb_q <= NB_MID;
			end
			S_NDATA: begin
				pass_q <= rdata_q[7];
				h_q    <= rdata_q[7] ? '0 : hdata;
				x1_q   <= nbx <<< FRAC_BITS;
				x2_q   <= (nbx + P_ONE) <<< FRAC_BITS;
				y1_q   <= nby <<< FRAC_BITS;
				y2_q   <= (nby + P_ONE) <<< FRAC_BITS;
				sub_q  <= SUB_TOP;
			end
			S_SUB: begin
				num_q  <= NW'(sub_num);
				den_q  <= DW'(sub_den);
				axis_q <= AX_X;
			end
			S_LERP: begin
				md_d_q   <= axis_d;
				md_num_q <= num_q;
				md_den_q <= den_q;
			end
			S_LWAIT: begin
				if (md_stat.done) begin
					unique case (axis_q)
						AX_X: begin
							qx_q   <= lerp_sum;
							axis_q <= AX_Y;
						end
						AX_Y: begin
							qy_q   <= lerp_sum;
							axis_q <= AX_Z;
						end
						default: qz_q <= lerp_sum;
					endcase
				end
			end
			S_MISS: begin
				if (!last_sub) sub_q <= sub_next(sub_q);
			end
			S_NBDONE: begin
				unique case (nb_q)
					NB_MID:  nb_q <= NB_LO;
					NB_LO:   nb_q <= NB_HI;
					default: nb_q <= NB_HI;
				endcase
			end
			S_STEP: begin
				md_num_q <= NW'(stp_num);
				md_d_q   <= xmode ? dy_q : dx_q;
				md_den_q <= xmode ? adx_q : ady_q;
				if (xmode) i_q <= stp_major;
				else       j_q <= stp_major;
			end
			S_SWAIT: begin
				if (md_stat.done) begin
					// side coordinate of the new step
					if (xmode) j_q <= tdiv(a1y_q + md_quot);
					else       i_q <= tdiv(a1x_q + md_quot);
				end
			end
			default: begin
			end
		endcase
	end

	`HGRH_ASSERT(a_query_busy, acc && (func == FUNC_QUERY) |=> busy, "query word did not start a walk")
	`HGRH_ASSERT(a_write_done, acc && (func == FUNC_WRITE) |=> done && !hit, "cell write gave no plain result")
	`HGRH_ASSERT_IMPL(a_done_idle, done, !busy && (hit == (outcome != OUT_NONE)), "result word inconsistent")
	`HGRH_ASSERT_IMPL(a_md_interlock, md_go_q, !md_stat.busy, "multiply-divide started while busy")

endmodule

`default_nettype wire
